// ===== src/wcwm_pkg.sv =====
// Shared constants, types and helper functions for the word concatenation window matcher.
// Used by the top level, wcwm_chunk_cut and wcwm_perm_check; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package wcwm_pkg;

  localparam int MAX_WORDS      = 6;
  localparam int MAX_WORD_CHARS = 8;
  localparam int INDEX_WIDTH    = 16;
  localparam int HIST_DEPTH     = MAX_WORDS * MAX_WORD_CHARS;
  localparam int POS_WIDTH      = INDEX_WIDTH + 1;
  localparam int CHAR_WIDTH     = 8;
  localparam int WORD_WIDTH     = CHAR_WIDTH * MAX_WORD_CHARS;
  localparam int LEN_WIDTH      = 4;
  localparam int COUNT_WIDTH    = 3;
  localparam int TAP_WIDTH      = $clog2(HIST_DEPTH);
  localparam int TOTAL_WIDTH    = $clog2(HIST_DEPTH + 1);
  localparam int WORD_SEL_WIDTH = $clog2(MAX_WORDS);
  localparam int CFG_INDEX_WIDTH = 3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_WORD_LEN   = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_WORD_COUNT = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_WORD_FIRST = 3'd2;

  typedef logic [WORD_WIDTH-1:0]                   word_t;
  typedef logic [MAX_WORDS-1:0][WORD_WIDTH-1:0]    word_array_t;
  typedef logic [HIST_DEPTH-1:0][CHAR_WIDTH-1:0]   hist_t;

  // Effective window geometry, derived from the configuration registers.
  typedef struct packed {
    logic [LEN_WIDTH-1:0]   len;
    logic [COUNT_WIDTH-1:0] count;
    logic [TOTAL_WIDTH-1:0] total;
  } geom_t;

  function automatic geom_t make_geom(logic [LEN_WIDTH-1:0] len_raw,
                                      logic [COUNT_WIDTH-1:0] word_count);
    geom_t g;
    g.len = len_raw;
    if (len_raw == '0) g.len = LEN_WIDTH'(1);
    if (len_raw > LEN_WIDTH'(MAX_WORD_CHARS)) g.len = LEN_WIDTH'(MAX_WORD_CHARS);
    g.count = word_count;
    if (word_count == '0) g.count = COUNT_WIDTH'(1);
    if (word_count > COUNT_WIDTH'(MAX_WORDS)) g.count = COUNT_WIDTH'(MAX_WORDS);
    g.total = TOTAL_WIDTH'(g.len) * TOTAL_WIDTH'(g.count);
    return g;
  endfunction

  // Keeps the low len bytes of a word.
  function automatic word_t byte_mask(logic [LEN_WIDTH-1:0] len);
    word_t m;
    for (int b = 0; b < MAX_WORD_CHARS; b++) begin
      m[CHAR_WIDTH*b +: CHAR_WIDTH] = (b < int'(len)) ? {CHAR_WIDTH{1'b1}} : '0;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== src/word_concatenation_window_matcher.sv =====
// Top level: character history, position counter, pipeline control and configuration.
// Uses wcwm_pkg, wcwm_chunk_cut and wcwm_perm_check.
// A result passes the history, chunk and output registers after its closing character beat is accepted.
// Throughput: one character per cycle; the input stalls only while a pending window
// is blocked behind a result that the output side is stalling.
// Reset (rst, synchronous): empties the pipeline, clears the position counter and
// restores the registers to word length 1, word count 1 and all words zero.
`timescale 1ns / 1ps
`default_nettype none

module word_concatenation_window_matcher (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  char_valid,
  output logic                                 char_stall,
  input  wire [wcwm_pkg::CHAR_WIDTH-1:0]       char_in,
  input  wire                                  first,
  output logic                                 result_valid,
  input  wire                                  result_stall,
  output logic [wcwm_pkg::INDEX_WIDTH-1:0]     start_index,
  input  wire                                  cfg_we,
  input  wire [wcwm_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  wire [wcwm_pkg::WORD_WIDTH-1:0]       cfg_data
);
  import wcwm_pkg::*;

  localparam logic [POS_WIDTH-1:0] POS_SAT = {POS_WIDTH{1'b1}};

  // Configuration
  logic [LEN_WIDTH-1:0]   len_cfg;
  logic [COUNT_WIDTH-1:0] word_count;
  word_array_t            words;
  geom_t                  geom;

  // History stage
  hist_t                  hist;
  logic [POS_WIDTH-1:0]   pos;
  logic                   hist_pending;
  logic [INDEX_WIDTH-1:0] hist_start;

  // Chunk stage
  logic                   s1_valid;
  logic [INDEX_WIDTH-1:0] s1_start;
  word_array_t            s1_chunks;

  word_array_t            chunks_next;
  logic                   match;

  logic                   accept;
  logic                   out_free;
  logic                   s1_move;
  logic                   s1_free;
  logic                   s1_load;
  logic                   out_load;
  logic [POS_WIDTH-1:0]   pos_base;
  logic [POS_WIDTH-1:0]   pos_next;
  logic [POS_WIDTH-1:0]   diff;
  logic                   window_hit;

  assign geom = make_geom(len_cfg, word_count);

  wcwm_chunk_cut u_chunk_cut (
    .geom   (geom),
    .hist   (hist),
    .chunks (chunks_next)
  );

  wcwm_perm_check u_perm_check (
    .geom   (geom),
    .words  (words),
    .chunks (s1_chunks),
    .match  (match)
  );

  always_comb begin
    out_free   = !result_valid || !result_stall;
    out_load   = s1_valid && match && out_free;
    s1_move    = s1_valid && (out_free || !match);
    s1_free    = !s1_valid || s1_move;
    s1_load    = hist_pending && s1_free;
    char_stall = hist_pending && !s1_free;
    accept     = char_valid && !char_stall;

    pos_base   = first ? '0 : pos;
    pos_next   = (pos_base == POS_SAT) ? pos_base : pos_base + POS_WIDTH'(1);
    diff       = pos_next - POS_WIDTH'(geom.total);
    // A start index beyond the output range gives no result.
    window_hit = (pos_next >= POS_WIDTH'(geom.total)) && !diff[POS_WIDTH-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_cfg    <= LEN_WIDTH'(1);
      word_count <= COUNT_WIDTH'(1);
      words      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WORD_LEN:   len_cfg    <= cfg_data[LEN_WIDTH-1:0];
        REG_WORD_COUNT: word_count <= cfg_data[COUNT_WIDTH-1:0];
        default:        words[WORD_SEL_WIDTH'(cfg_index - REG_WORD_FIRST)] <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      hist_pending <= 1'b0;
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        pos          <= pos_next;
        hist_pending <= window_hit;
      end else if (s1_load) begin
        hist_pending <= 1'b0;
      end

      if (s1_load) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end

      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hist       <= {hist[HIST_DEPTH-2:0], char_in};
      hist_start <= diff[INDEX_WIDTH-1:0];
    end
    if (s1_load) begin
      s1_chunks <= chunks_next;
      s1_start  <= hist_start;
    end
    if (out_load) begin
      start_index <= s1_start;
    end
  end

endmodule

`default_nettype wire

// ===== src/wcwm_chunk_cut.sv =====
// Cuts the current window of the character history into word-sized chunks.
// Combinational; uses wcwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wcwm_chunk_cut (
  input  wire wcwm_pkg::geom_t       geom,
  input  wire wcwm_pkg::hist_t       hist,
  output wcwm_pkg::word_array_t      chunks
);
  import wcwm_pkg::*;

  logic [TAP_WIDTH-1:0] tap    [MAX_WORDS][MAX_WORD_CHARS];
  logic                 in_use [MAX_WORDS][MAX_WORD_CHARS];

  // Entry 0 of the history is the newest character, so the window's first
  // character sits at entry total-1 and the chunks run towards entry 0.
  always_comb begin
    for (int k = 0; k < MAX_WORDS; k++) begin
      for (int j = 0; j < MAX_WORD_CHARS; j++) begin
        tap[k][j]    = TAP_WIDTH'(int'(geom.total) - 1 - k * int'(geom.len) - j);
        in_use[k][j] = (k < int'(geom.count)) && (j < int'(geom.len));
        chunks[k][CHAR_WIDTH*j +: CHAR_WIDTH] = in_use[k][j] ? hist[tap[k][j]] : '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/wcwm_perm_check.sv =====
// Decides whether the chunks are a permutation of the configured words, duplicates counted.
// Combinational; uses wcwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wcwm_perm_check (
  input  wire wcwm_pkg::geom_t       geom,
  input  wire wcwm_pkg::word_array_t words,
  input  wire wcwm_pkg::word_array_t chunks,
  output logic                       match
);
  import wcwm_pkg::*;

  localparam int CNT_WIDTH = $clog2(MAX_WORDS + 1);

  word_t                mask;
  logic [CNT_WIDTH-1:0] in_chunks [MAX_WORDS];
  logic [CNT_WIDTH-1:0] in_words  [MAX_WORDS];

  // Each chunk must occur among the chunks exactly as often as among the
  // words; over all chunks this is multiset equality.
  always_comb begin
    mask  = byte_mask(geom.len);
    match = 1'b1;
    for (int k = 0; k < MAX_WORDS; k++) begin
      in_chunks[k] = '0;
      in_words[k]  = '0;
      for (int j = 0; j < MAX_WORDS; j++) begin
        if (j < int'(geom.count)) begin
          if (chunks[j] == chunks[k]) in_chunks[k] = in_chunks[k] + CNT_WIDTH'(1);
          if ((words[j] & mask) == chunks[k]) in_words[k] = in_words[k] + CNT_WIDTH'(1);
        end
      end
      if ((k < int'(geom.count)) && (in_chunks[k] != in_words[k])) match = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== src/wcwm_checker.sv =====
// Port-level checks on the word concatenation window matcher, bound to the top level.
// Sees only the top-level ports; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module wcwm_checker (
  input wire        clk,
  input wire        rst,
  input wire        char_valid,
  input wire        char_stall,
  input wire        result_valid,
  input wire        result_stall,
  input wire [15:0] start_index
);

  // A stalled result beat holds its value.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(start_index))
    else $error("stalled result beat changed");

  // Reset empties the pipeline.
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result beat present after reset");

  // The input is only held off by back-pressure on the result side.
  assert property (@(posedge clk) disable iff (rst)
    char_stall |-> result_valid && result_stall)
    else $error("character input stalled without result back-pressure");

  // An idle pipeline takes characters at once.
  assert property (@(posedge clk) disable iff (rst)
    !char_valid && !result_valid |=> !char_stall)
    else $error("character input stalled while the pipeline was idle");

endmodule

bind word_concatenation_window_matcher wcwm_checker u_wcwm_checker (.*);

`default_nettype wire
